>>> hdl/ncdf_pkg.sv
package ncdf_pkg;

	localparam int INPUT_WIDTH_DEF = 16;
	localparam int FRAC_BITS       = 12;
	localparam int OUT_WIDTH       = 16;
	localparam int DIV_STEPS       = 17;

	localparam logic [15:0] INV_SQRT2_Q16 = 16'd46341;
	localparam logic [14:0] P_Q16         = 15'd21469;
	localparam logic [16:0] LOG2E_Q16     = 17'd94548;
	localparam logic [16:0] Q16_ONE       = 17'd65536;
	localparam logic [15:0] Z_MAX_Q12     = 16'd32768;

	localparam logic signed [17:0] A5 = 18'sd69560;
	localparam logic signed [17:0] A4 = -18'sd95234;
	localparam logic signed [17:0] A3 = 18'sd93154;
	localparam logic signed [17:0] A2 = -18'sd18645;
	localparam logic signed [17:0] A1 = 18'sd16701;

	function automatic logic [16:0] exp2_tab(input logic [4:0] idx);
		logic [16:0] v;
		case (idx)
			5'd0:  v = 17'd65536;
			5'd1:  v = 17'd62757;
			5'd2:  v = 17'd60097;
			5'd3:  v = 17'd57549;
			5'd4:  v = 17'd55109;
			5'd5:  v = 17'd52773;
			5'd6:  v = 17'd50535;
			5'd7:  v = 17'd48393;
			5'd8:  v = 17'd46341;
			5'd9:  v = 17'd44376;
			5'd10: v = 17'd42495;
			5'd11: v = 17'd40693;
			5'd12: v = 17'd38968;
			5'd13: v = 17'd37316;
			5'd14: v = 17'd35734;
			5'd15: v = 17'd34219;
			5'd16: v = 17'd32768;
			default: v = 17'd32768;
		endcase
		return v;
	endfunction

	function automatic logic signed [17:0] rnd16(input logic signed [35:0] v);
		logic [35:0] mag;
		logic [19:0] r;
		mag = v[35] ? 36'(-v) : 36'(v);
		r = 20'((mag + 36'd32768) >> 16);
		return v[35] ? -18'(r) : 18'(r);
	endfunction

endpackage

>>> hdl/normal_cdf_approximation.sv
// Throughput: one item per cycle unless out_ready stalls the pipeline; the 17-step
// restoring divider is unrolled one quotient bit per pipeline stage and sets the depth.
// A stall holds each occupied stage behind it up to the nearest bubble; bubbles are squeezed out as they advance.
// arst_n clears all valid bits; payload registers are not reset.
module normal_cdf_approximation #(
	parameter int INPUT_WIDTH = ncdf_pkg::INPUT_WIDTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [INPUT_WIDTH-1:0] x_value,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [15:0]            cdf_value
);
	import ncdf_pkg::*;

	localparam int NST = 5 + DIV_STEPS + 7;
	localparam int AXW = INPUT_WIDTH;
	localparam int ZW  = (AXW + 1 > 17) ? AXW + 1 : 17;

	logic [NST-1:0] vld_q;
	logic [NST-1:0] adv;

	always_comb begin
		adv[NST-1] = !vld_q[NST-1] || out_ready;
		for (int i = NST - 2; i >= 0; i--)
			adv[i] = !vld_q[i] || adv[i+1];
	end

	assign in_ready  = adv[0];
	assign out_valid = vld_q[NST-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (adv[0])
				vld_q[0] <= in_valid;
			for (int i = 1; i < NST; i++)
				if (adv[i])
					vld_q[i] <= vld_q[i-1];
		end
	end

	// stage 0: sign and magnitude
	logic           neg_s1;
	logic [AXW-1:0] ax_s1;
	always_ff @(posedge clk) begin
		if (adv[0]) begin
			neg_s1 <= x_value[INPUT_WIDTH-1];
			ax_s1  <= x_value[INPUT_WIDTH-1] ? AXW'(-x_value) : x_value;
		end
	end

	// stage 1: z = |x|/sqrt2, saturated
	logic [AXW+15:0] zp;
	logic [AXW:0]    zr;
	logic            neg_s2;
	logic [15:0]     z_s2;
	assign zp = AXW'(0) + (ax_s1 * INV_SQRT2_Q16) + (AXW+16)'(32768);
	assign zr = zp[AXW+15:15] >> 1;
	always_ff @(posedge clk) begin
		if (adv[1]) begin
			neg_s2 <= neg_s1;
			z_s2   <= (ZW'(zr) > ZW'(Z_MAX_Q12)) ? Z_MAX_Q12 : 16'(zr);
		end
	end

	// stage 2: d = 1 + p*z, w = z*z
	logic [30:0] dp;
	logic        neg_s3;
	logic [15:0] d_s3;
	logic [31:0] w_s3;
	assign dp = 31'(z_s2) * 31'(P_Q16) + 31'd32768;
	always_ff @(posedge clk) begin
		if (adv[2]) begin
			neg_s3 <= neg_s2;
			d_s3   <= 16'd4096 + 16'(dp[30:16]);
			w_s3   <= 32'(z_s2) * 32'(z_s2);
		end
	end

	// stage 3: u = w*log2e
	logic [49:0] up;
	logic        neg_s4;
	logic [15:0] d_s4;
	logic [25:0] u_s4;
	assign up = 50'(w_s3) * 50'(LOG2E_Q16) + 50'd8388608;
	always_ff @(posedge clk) begin
		if (adv[3]) begin
			neg_s4 <= neg_s3;
			d_s4   <= d_s3;
			u_s4   <= up[49:24];
		end
	end

	// stage 4: table lookup, interpolation product
	logic [16:0] ta, tb;
	logic        neg_s5;
	logic [15:0] d_s5;
	logic [9:0]  k_s5;
	logic [16:0] ta_s5;
	logic [29:0] ip_s5;
	assign ta = exp2_tab({1'b0, u_s4[15:12]});
	assign tb = exp2_tab(5'({1'b0, u_s4[15:12]} + 5'd1));
	always_ff @(posedge clk) begin
		if (adv[4]) begin
			neg_s5 <= neg_s4;
			d_s5   <= d_s4;
			k_s5   <= u_s4[25:16];
			ta_s5  <= ta;
			ip_s5  <= 30'(ta - tb) * 30'(u_s4[11:0]) + 30'd2048;
		end
	end

	// divider: 17 stages, one quotient bit each, t = 2^28 / d
	logic               dneg [DIV_STEPS+1];
	logic [16:0]        drem [DIV_STEPS+1];
	logic [16:0]        dq   [DIV_STEPS+1];
	logic [15:0]        dd   [DIV_STEPS+1];
	logic [16:0]        dg   [DIV_STEPS+1];
	logic [9:0]         dk   [DIV_STEPS+1];

	assign dneg[0] = neg_s5;
	assign drem[0] = 17'd4096;
	assign dq[0]   = '0;
	assign dd[0]   = d_s5;
	assign dg[0]   = ta_s5 - 17'(ip_s5[29:12]);
	assign dk[0]   = k_s5;

	for (genvar g = 0; g < DIV_STEPS; g++) begin : g_div
		logic [17:0] trial;
		logic [16:0] rem_n;
		logic        bit_n;
		assign trial = {1'b0, drem[g]} - {2'b0, dd[g]};
		assign bit_n = !trial[17];
		assign rem_n = bit_n ? 17'({trial[15:0], 1'b0}) : {drem[g][15:0], 1'b0};
		always_ff @(posedge clk) begin
			if (adv[5+g]) begin
				dneg[g+1] <= dneg[g];
				drem[g+1] <= rem_n;
				dq[g+1]   <= {dq[g][15:0], bit_n};
				dd[g+1]   <= dd[g];
				dg[g+1]   <= dg[g];
				dk[g+1]   <= dk[g];
			end
		end
	end

	localparam int PB = 5 + DIV_STEPS;

	// exponent shift, combined with the first Horner step
	logic [16:0] e_c;
	logic [16:0] gk;
	assign gk = dg[DIV_STEPS];
	always_comb begin
		if (dk[DIV_STEPS] == 10'd0)
			e_c = gk;
		else if (dk[DIV_STEPS] > 10'd16)
			e_c = '0;
		else
			e_c = 17'(({1'b0, gk} + (18'd1 << (dk[DIV_STEPS] - 10'd1))) >> dk[DIV_STEPS]);
	end

	logic               neg_h [6];
	logic [16:0]        t_h   [6];
	logic [16:0]        e_h   [6];
	logic signed [17:0] acc_h [6];
	logic signed [17:0] coef  [5];
	assign coef[0] = A4;
	assign coef[1] = A3;
	assign coef[2] = A2;
	assign coef[3] = A1;
	assign coef[4] = '0;

	assign neg_h[0] = dneg[DIV_STEPS];
	assign t_h[0]   = dq[DIV_STEPS];
	assign e_h[0]   = e_c;
	assign acc_h[0] = A5;

	for (genvar h = 0; h < 5; h++) begin : g_horner
		logic signed [35:0] prod;
		assign prod = acc_h[h] * $signed({1'b0, t_h[h]});
		always_ff @(posedge clk) begin
			if (adv[PB+h]) begin
				neg_h[h+1] <= neg_h[h];
				t_h[h+1]   <= t_h[h];
				e_h[h+1]   <= e_h[h];
				acc_h[h+1] <= rnd16(prod) + coef[h];
			end
		end
	end

	// clamp poly, multiply by exp
	logic [16:0] poly;
	logic        neg_m;
	logic [33:0] m_full;
	always_comb begin
		if (acc_h[5] < 0)
			poly = '0;
		else if (acc_h[5] > $signed({1'b0, Q16_ONE}))
			poly = Q16_ONE;
		else
			poly = 17'(acc_h[5]);
	end

	logic        neg_s28;
	logic [33:0] mp_s28;
	always_ff @(posedge clk) begin
		if (adv[PB+5]) begin
			neg_s28 <= neg_h[5];
			mp_s28  <= 34'(poly) * 34'(e_h[5]) + 34'd32768;
		end
	end

	logic [17:0] m;
	logic [16:0] y;
	logic [17:0] cdf;
	assign m_full = mp_s28;
	assign m = (m_full[33:16] > 18'(Q16_ONE)) ? 18'(Q16_ONE) : m_full[33:16];
	assign y = 17'(18'(Q16_ONE) - m);
	assign cdf = neg_s28 ? ((18'(Q16_ONE) - 18'(y) + 18'd1) >> 1)
		: ((18'(Q16_ONE) + 18'(y) + 18'd1) >> 1);
	assign neg_m = neg_s28;

	logic [15:0] out_s29;
	always_ff @(posedge clk) begin
		if (adv[PB+6])
			out_s29 <= (cdf > 18'd65535 && !neg_m) ? 16'hFFFF : 16'(cdf);
	end

	assign cdf_value = out_s29;

endmodule
